/* rtl/core/kmzr_pkg.sv */
`timescale 1ns / 1ps

package kmzr_pkg;

  // Fixed-point formats
  localparam int COORD_W  = 32;                  // Q4.28 coordinates
  localparam int METRIC_W = 32;                  // Q8.24 metric entries
  localparam int GM_W     = 36;                  // metric times lattice vector
  localparam int ACC_W    = 44;                  // mGm and fGm accumulators
  localparam int MUL_A_W  = 37;
  localparam int MUL_B_W  = 19;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int HALF_W   = 18;                  // split of Gm for the f*Gm products
  localparam int Q_W      = 22;                  // clamped multiple
  localparam int DIV_W    = 64;
  localparam int QUOT_W   = 32;
  localparam int CNT_W    = 6;

  localparam int Q_LIMIT  = 1 << 20;
  localparam int Q_BITS   = 21;                  // quotient bits before clamping
  localparam int START_BITS = 28;                // quotient bits of a start coordinate

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_AA = 3'd0;
  localparam logic [2:0] REG_BB = 3'd1;
  localparam logic [2:0] REG_CC = 3'd2;
  localparam logic [2:0] REG_AB = 3'd3;
  localparam logic [2:0] REG_AC = 3'd4;
  localparam logic [2:0] REG_BC = 3'd5;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den_sh;   // divisor already shifted to the top quotient bit
    logic [CNT_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

/* rtl/core/kmzr_mul.sv */
`timescale 1ns / 1ps

module kmzr_mul (
  input  logic                                 clk,
  input  logic signed [kmzr_pkg::MUL_A_W-1:0]  a,
  input  logic signed [kmzr_pkg::MUL_B_W-1:0]  b,
  output logic signed [kmzr_pkg::MUL_P_W-1:0]  p
);

  // Register each product
  always_ff @(posedge clk) begin
    p <= kmzr_pkg::MUL_P_W'(a) * kmzr_pkg::MUL_P_W'(b);
  end

endmodule

/* rtl/core/kmzr_div.sv */
`timescale 1ns / 1ps

module kmzr_div (
  input  logic                clk,
  input  logic                rst,
  input  kmzr_pkg::div_req_t  req,
  output kmzr_pkg::div_rsp_t  rsp
);

  logic [kmzr_pkg::DIV_W-1:0]  rem;
  logic [kmzr_pkg::DIV_W-1:0]  dsh;
  logic [kmzr_pkg::QUOT_W-1:0] quot;
  logic [kmzr_pkg::CNT_W-1:0]  cnt;
  logic                        done;
  logic                        fits;

  assign fits = rem >= dsh;

  // Count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= req.nbits;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == kmzr_pkg::CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsh  <= req.den_sh;
      quot <= '0;
    end else if (cnt != '0) begin
      if (fits) rem <= rem - dsh;
      quot <= {quot[kmzr_pkg::QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp.done   = done;
  assign rsp.quot   = quot;
  assign rsp.rem_nz = rem != '0;

endmodule

/* rtl/core/kpoint_mesh_zone_reduce.sv */
`timescale 1ns / 1ps

// Sequence: three 28-bit divides give the start coordinates, then each of the 124 lattice
// vectors takes 18 steps on the shared 37x19 multiplier, 1 setup, a 21-bit divide and 1 update.
// A vector of non-positive norm is skipped after its mGm steps; a clamped multiple skips the
// divide; an index fault goes straight to the output.
// One item at a time; a held result stalls the next.
// Reset (rst, synchronous): sequencer idle, output empty, metric registers to identity.
module kpoint_mesh_zone_reduce #(
  parameter int SEARCH_RADIUS = 2,
  parameter int MESH_MAX      = 64
) (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: mesh_count_a[6:0], mesh_count_b[13:7], mesh_count_c[20:14],
  //          index_a[26:21], index_b[32:27], index_c[38:33], zero fill
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,
  // m_tdata: coord_a[31:0], coord_b[63:32], coord_c[95:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,
  // m_tuser: status[1:0]
  output logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = kmzr_pkg::COORD_W;
  localparam int AW = kmzr_pkg::MUL_A_W;
  localparam int BW = kmzr_pkg::MUL_B_W;
  localparam int PW = kmzr_pkg::MUL_P_W;
  localparam int GW = kmzr_pkg::GM_W;
  localparam int XW = kmzr_pkg::ACC_W;
  localparam int DW = kmzr_pkg::DIV_W;
  localparam int QW = kmzr_pkg::Q_W;
  localparam int HW = kmzr_pkg::HALF_W;
  localparam int NW = 48;
  localparam int WW = 56;
  localparam int FW = 72;
  localparam logic signed [3:0] RAD = 4'(SEARCH_RADIUS);
  localparam logic [8:0] MESH_LIM = 9'(MESH_MAX);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SINIT = 3'd1;
  localparam logic [2:0] S_SDIV  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_QINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;

  // Configuration registers
  logic signed [31:0] m_aa, m_bb, m_cc, m_ab, m_ac, m_bc;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_aa <= 32'sd16777216;
      m_bb <= 32'sd16777216;
      m_cc <= 32'sd16777216;
      m_ab <= '0;
      m_ac <= '0;
      m_bc <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        kmzr_pkg::REG_AA: m_aa <= pwdata;
        kmzr_pkg::REG_BB: m_bb <= pwdata;
        kmzr_pkg::REG_CC: m_cc <= pwdata;
        kmzr_pkg::REG_AB: m_ab <= pwdata;
        kmzr_pkg::REG_AC: m_ac <= pwdata;
        kmzr_pkg::REG_BC: m_bc <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      kmzr_pkg::REG_AA: prdata = m_aa;
      kmzr_pkg::REG_BB: prdata = m_bb;
      kmzr_pkg::REG_CC: prdata = m_cc;
      kmzr_pkg::REG_AB: prdata = m_ab;
      kmzr_pkg::REG_AC: prdata = m_ac;
      kmzr_pkg::REG_BC: prdata = m_bc;
      default:          prdata = '0;
    endcase
  end

  // Input check
  logic [6:0] in_n [3];
  logic [5:0] in_i [3];
  logic       in_fault;

  always_comb begin
    in_n[0] = s_tdata[6:0];
    in_n[1] = s_tdata[13:7];
    in_n[2] = s_tdata[20:14];
    in_i[0] = s_tdata[26:21];
    in_i[1] = s_tdata[32:27];
    in_i[2] = s_tdata[38:33];
    in_fault = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (in_n[j] == '0 || {2'b0, in_n[j]} > MESH_LIM || {1'b0, in_i[j]} >= in_n[j])
        in_fault = 1'b1;
    end
  end

  assign s_tready = state == S_IDLE;

  // Working registers
  logic [6:0]          n_r [3];
  logic [5:0]          i_r [3];
  logic [1:0]          ax;
  logic signed [CW-1:0] f [3];
  logic signed [3:0]   mv [3];
  logic [4:0]          st;
  logic                ph;
  logic signed [GW-1:0] gm [3];
  logic signed [XW-1:0] mgm, fgm;
  logic signed [PW-1:0] tmp;
  logic signed [QW-1:0] q;
  logic                x_neg;
  logic [1:0]          status;

  // Shared units
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  kmzr_pkg::div_req_t   div_req;
  kmzr_pkg::div_rsp_t   div_rsp;

  kmzr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  kmzr_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Select multiplier operands by micro step
  function automatic logic signed [BW-1:0] gm_lo(input logic signed [GW-1:0] g);
    return BW'({1'b0, g[HW-1:0]});
  endfunction

  function automatic logic signed [BW-1:0] gm_hi(input logic signed [GW-1:0] g);
    return BW'($signed(g[GW-1:HW]));
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      5'd0:  begin mul_a = AW'(m_aa);  mul_b = BW'(mv[0]); end
      5'd1:  begin mul_a = AW'(m_ab);  mul_b = BW'(mv[1]); end
      5'd2:  begin mul_a = AW'(m_ac);  mul_b = BW'(mv[2]); end
      5'd3:  begin mul_a = AW'(m_ab);  mul_b = BW'(mv[0]); end
      5'd4:  begin mul_a = AW'(m_bb);  mul_b = BW'(mv[1]); end
      5'd5:  begin mul_a = AW'(m_bc);  mul_b = BW'(mv[2]); end
      5'd6:  begin mul_a = AW'(m_ac);  mul_b = BW'(mv[0]); end
      5'd7:  begin mul_a = AW'(m_bc);  mul_b = BW'(mv[1]); end
      5'd8:  begin mul_a = AW'(m_cc);  mul_b = BW'(mv[2]); end
      5'd9:  begin mul_a = AW'(gm[0]); mul_b = BW'(mv[0]); end
      5'd10: begin mul_a = AW'(gm[1]); mul_b = BW'(mv[1]); end
      5'd11: begin mul_a = AW'(gm[2]); mul_b = BW'(mv[2]); end
      5'd12: begin mul_a = AW'(f[0]);  mul_b = gm_lo(gm[0]); end
      5'd13: begin mul_a = AW'(f[0]);  mul_b = gm_hi(gm[0]); end
      5'd14: begin mul_a = AW'(f[1]);  mul_b = gm_lo(gm[1]); end
      5'd15: begin mul_a = AW'(f[1]);  mul_b = gm_hi(gm[1]); end
      5'd16: begin mul_a = AW'(f[2]);  mul_b = gm_lo(gm[2]); end
      5'd17: begin mul_a = AW'(f[2]);  mul_b = gm_hi(gm[2]); end
      default: ;
    endcase
  end

  // Next lattice vector, skipping the origin
  function automatic logic [11:0] vec_inc(input logic [11:0] v);
    logic signed [3:0] c0, c1, c2;
    c0 = v[3:0];
    c1 = v[7:4];
    c2 = v[11:8];
    if (c2 != RAD) begin
      c2 = c2 + 4'sd1;
    end else begin
      c2 = -RAD;
      if (c1 != RAD) begin
        c1 = c1 + 4'sd1;
      end else begin
        c1 = -RAD;
        c0 = c0 + 4'sd1;
      end
    end
    return {c2, c1, c0};
  endfunction

  logic [11:0] v_cur, v_n1, v_next;
  logic        v_last;

  always_comb begin
    v_cur  = {mv[2], mv[1], mv[0]};
    v_n1   = vec_inc(v_cur);
    v_next = (v_n1 == '0) ? vec_inc(v_n1) : v_n1;
    v_last = mv[0] == RAD && mv[1] == RAD && mv[2] == RAD;
  end

  // Accumulation terms
  logic signed [XW-1:0] mgm_sum;
  logic signed [FW-1:0] fprod;
  logic signed [XW-1:0] fgm_sum;

  always_comb begin
    mgm_sum = mgm + XW'(mul_p);
    fprod   = FW'(tmp) + (FW'(mul_p) <<< HW);
    fgm_sum = fgm + XW'(fprod >>> 28);
  end

  // Start coordinate operands
  logic signed [8:0] s_num;
  logic [8:0]        s_mag;

  always_comb begin
    s_num = 9'(n_r[ax]) - 9'sd1 - 9'(signed'({1'b0, i_r[ax], 1'b0}));
    s_mag = s_num[8] ? 9'(-s_num) : 9'(s_num);
  end

  // Quotient operands
  logic signed [NW-1:0] x_val;
  logic [NW-1:0]        x_mag, d_val;
  logic                 q_big;

  always_comb begin
    x_val = (NW'(fgm) <<< 1) - NW'(mgm);
    x_mag = x_val[NW-1] ? NW'(-x_val) : NW'(x_val);
    d_val = NW'(mgm) << 1;
    q_big = DW'(x_mag) >= (DW'(d_val) << kmzr_pkg::Q_BITS);
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    if (state == S_SINIT) begin
      div_req.start  = 1'b1;
      div_req.num    = (DW'(s_mag) << 29) + DW'({n_r[ax], 1'b0});
      div_req.den_sh = DW'({n_r[ax], 2'b0}) << (kmzr_pkg::START_BITS - 1);
      div_req.nbits  = kmzr_pkg::CNT_W'(kmzr_pkg::START_BITS);
    end else if (state == S_QINIT && !q_big) begin
      div_req.start  = 1'b1;
      div_req.num    = DW'(x_mag);
      div_req.den_sh = DW'(d_val) << (kmzr_pkg::Q_BITS - 1);
      div_req.nbits  = kmzr_pkg::CNT_W'(kmzr_pkg::Q_BITS);
    end
  end

  // Ceiling from the divider result, then clamp
  logic signed [QW+1:0] q_raw;
  logic                 q_hi, q_lo;

  always_comb begin
    q_raw = x_neg ? -(QW+2)'(div_rsp.quot[kmzr_pkg::Q_BITS-1:0])
                  : (QW+2)'(div_rsp.quot[kmzr_pkg::Q_BITS-1:0]) + (QW+2)'(div_rsp.rem_nz);
    q_hi  = q_raw >  (QW+2)'(kmzr_pkg::Q_LIMIT);
    q_lo  = q_raw < -(QW+2)'(kmzr_pkg::Q_LIMIT);
  end

  // Coordinate update with saturation
  logic signed [CW-1:0] f_upd [3];
  logic [2:0]           f_sat;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [WW-1:0] qm;
      logic signed [WW-1:0] v;
      qm = WW'(q) * WW'(mv[j]);
      v  = WW'(f[j]) - (qm <<< 28);
      f_sat[j] = 1'b1;
      if (v > WW'(32'sh7fffffff)) begin
        f_upd[j] = 32'sh7fffffff;
      end else if (v < WW'(-33'sh80000000)) begin
        f_upd[j] = 32'sh80000000;
      end else begin
        f_upd[j] = v[CW-1:0];
        f_sat[j] = 1'b0;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (s_tvalid) state <= in_fault ? S_OUT : S_SINIT;
        S_SINIT: state <= S_SDIV;
        S_SDIV:  if (div_rsp.done) state <= (ax == 2'd2) ? S_MUL : S_SINIT;
        S_MUL: begin
          if (ph) begin
            if (st == 5'd11 && mgm_sum <= 0) state <= v_last ? S_OUT : S_MUL;
            else if (st == 5'd17) state <= S_QINIT;
          end
        end
        S_QINIT: state <= q_big ? S_UPD : S_DIV;
        S_DIV:   if (div_rsp.done) state <= S_UPD;
        S_UPD:   state <= v_last ? S_OUT : S_MUL;
        S_OUT:   if (!m_tvalid || m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        for (int j = 0; j < 3; j++) begin
          n_r[j] <= in_n[j];
          i_r[j] <= in_i[j];
          f[j]   <= '0;
        end
        ax     <= '0;
        status <= in_fault ? kmzr_pkg::ST_INDEX : kmzr_pkg::ST_OK;
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          f[ax] <= s_num[8] ? -CW'(div_rsp.quot) : CW'(div_rsp.quot);
          ax    <= ax + 2'd1;
          for (int j = 0; j < 3; j++) begin
            mv[j] <= -RAD;
            gm[j] <= '0;
          end
          st  <= '0;
          ph  <= 1'b0;
          mgm <= '0;
          fgm <= '0;
        end
      end
      S_MUL: begin
        ph <= ~ph;
        if (ph) begin
          if (st == 5'd11 && mgm_sum <= 0) begin
            // Degenerate vector: skip it
            {mv[2], mv[1], mv[0]} <= v_next;
            st  <= '0;
            for (int j = 0; j < 3; j++) gm[j] <= '0;
            mgm <= '0;
            fgm <= '0;
          end else begin
            st <= st + 5'd1;
            unique case (st)
              5'd0, 5'd1, 5'd2:    gm[0] <= gm[0] + GW'(mul_p);
              5'd3, 5'd4, 5'd5:    gm[1] <= gm[1] + GW'(mul_p);
              5'd6, 5'd7, 5'd8:    gm[2] <= gm[2] + GW'(mul_p);
              5'd9, 5'd10, 5'd11:  mgm   <= mgm_sum;
              5'd12, 5'd14, 5'd16: tmp   <= mul_p;
              5'd13, 5'd15, 5'd17: fgm   <= fgm_sum;
              default: ;
            endcase
          end
        end
      end
      S_QINIT: begin
        x_neg <= x_val[NW-1];
        if (q_big) begin
          q      <= x_val[NW-1] ? -QW'(kmzr_pkg::Q_LIMIT) : QW'(kmzr_pkg::Q_LIMIT);
          status <= kmzr_pkg::ST_SAT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (q_hi) begin
            q      <= QW'(kmzr_pkg::Q_LIMIT);
            status <= kmzr_pkg::ST_SAT;
          end else if (q_lo) begin
            q      <= -QW'(kmzr_pkg::Q_LIMIT);
            status <= kmzr_pkg::ST_SAT;
          end else begin
            q <= q_raw[QW-1:0];
          end
        end
      end
      S_UPD: begin
        for (int j = 0; j < 3; j++) f[j] <= f_upd[j];
        if (f_sat != '0) status <= kmzr_pkg::ST_SAT;
        {mv[2], mv[1], mv[0]} <= v_next;
        st  <= '0;
        ph  <= 1'b0;
        for (int j = 0; j < 3; j++) gm[j] <= '0;
        mgm <= '0;
        fgm <= '0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {f[2], f[1], f[0]};
      m_tuser <= status;
    end
  end

`ifndef SYNTH
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == kmzr_pkg::ST_INDEX |-> m_tdata == '0)
    else $error("index fault result carries nonzero coordinates");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted beat did not start work");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_SDIV || state == S_DIV)
    else $error("divider finished outside a divide step");

  a_no_origin: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> !(mv[0] == 0 && mv[1] == 0 && mv[2] == 0))
    else $error("zero lattice vector visited");
`endif

endmodule

/* test/kmzr_checker.sv */
`timescale 1ns / 1ps

module kmzr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);

  localparam longint ONE_Q28 = 64'sd268435456;
  localparam longint Q_MAX   = 64'sd1048576;
  localparam int     RADIUS  = 2;
  localparam int     MESH_TOP = 64;

  typedef struct {
    logic signed [31:0] coord [3];
    logic [1:0]         status;
  } kpoint_t;

  kpoint_t reduced_q [$];

  // Shadow of the metric registers, sign extended
  longint g_aa, g_bb, g_cc, g_ab, g_ac, g_bc;

  function automatic longint start_frac(longint n, longint i);
    longint num, mag, d, r;
    num = n - 1 - 2 * i;
    mag = (num < 0) ? -num : num;
    d = 2 * n;
    r = (2 * mag * ONE_Q28 + d) / (2 * d);
    return (num < 0) ? -r : r;
  endfunction

  // floor(f * g / 2^28)
  function automatic longint frac_mul(longint f, longint g);
    logic signed [95:0] a, b, p;
    a = f;
    b = g;
    p = a * b;
    return longint'(p >>> 28);
  endfunction

  function automatic longint ceil_quot(longint x, longint d);
    if (x >= 0) return (x + d - 1) / d;
    return -((-x) / d);
  endfunction

  function automatic kpoint_t reduce_point(logic [39:0] d);
    kpoint_t r;
    longint n [3], idx [3], f [3], m [3], gm [3];
    longint mgm, fgm, q, v;
    logic [1:0] st;
    st = kmzr_pkg::ST_OK;
    for (int j = 0; j < 3; j++) begin
      n[j] = d[7*j +: 7];
      idx[j] = d[21 + 6*j +: 6];
      if (n[j] == 0 || n[j] > MESH_TOP || idx[j] >= n[j]) st = kmzr_pkg::ST_INDEX;
    end
    if (st == kmzr_pkg::ST_INDEX) begin
      for (int j = 0; j < 3; j++) r.coord[j] = '0;
      r.status = kmzr_pkg::ST_INDEX;
      return r;
    end
    for (int j = 0; j < 3; j++) f[j] = start_frac(n[j], idx[j]);
    // Walk the lattice cube, first component outermost
    for (int ix = -RADIUS; ix <= RADIUS; ix++)
      for (int iy = -RADIUS; iy <= RADIUS; iy++)
        for (int iz = -RADIUS; iz <= RADIUS; iz++) begin
          if (ix == 0 && iy == 0 && iz == 0) continue;
          m[0] = ix; m[1] = iy; m[2] = iz;
          gm[0] = g_aa * ix + g_ab * iy + g_ac * iz;
          gm[1] = g_ab * ix + g_bb * iy + g_bc * iz;
          gm[2] = g_ac * ix + g_bc * iy + g_cc * iz;
          mgm = ix * gm[0] + iy * gm[1] + iz * gm[2];
          // skip vectors of non-positive norm
          if (mgm <= 0) continue;
          fgm = frac_mul(f[0], gm[0]) + frac_mul(f[1], gm[1]) + frac_mul(f[2], gm[2]);
          q = ceil_quot(2 * fgm - mgm, 2 * mgm);
          if (q > Q_MAX) begin q = Q_MAX; st = kmzr_pkg::ST_SAT; end
          if (q < -Q_MAX) begin q = -Q_MAX; st = kmzr_pkg::ST_SAT; end
          for (int j = 0; j < 3; j++) begin
            v = f[j] - q * m[j] * ONE_Q28;
            if (v > 64'sd2147483647) begin v = 64'sd2147483647; st = kmzr_pkg::ST_SAT; end
            if (v < -64'sd2147483648) begin v = -64'sd2147483648; st = kmzr_pkg::ST_SAT; end
            f[j] = v;
          end
        end
    for (int j = 0; j < 3; j++) r.coord[j] = f[j][31:0];
    r.status = st;
    return r;
  endfunction

  assign pending = reduced_q.size();

  // Track writes, predict on input beats, compare on output beats
  always @(posedge clk) begin
    kpoint_t exp_r;
    int      miss;
    miss = 0;
    if (rst) begin
      g_aa <= 64'sd16777216; g_bb <= 64'sd16777216; g_cc <= 64'sd16777216;
      g_ab <= 0; g_ac <= 0; g_bc <= 0;
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          kmzr_pkg::REG_AA: g_aa <= longint'($signed(pwdata));
          kmzr_pkg::REG_BB: g_bb <= longint'($signed(pwdata));
          kmzr_pkg::REG_CC: g_cc <= longint'($signed(pwdata));
          kmzr_pkg::REG_AB: g_ab <= longint'($signed(pwdata));
          kmzr_pkg::REG_AC: g_ac <= longint'($signed(pwdata));
          kmzr_pkg::REG_BC: g_bc <= longint'($signed(pwdata));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) reduced_q = {reduced_q, reduce_point(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (reduced_q.size() == 0) begin
          $error("result beat with no point outstanding");
          miss++;
        end else begin
          exp_r = reduced_q.pop_front();
          for (int j = 0; j < 3; j++)
            if (m_tdata[32*j +: 32] !== exp_r.coord[j]) begin
              $error("coord_%0d expected %h got %h", j, exp_r.coord[j], m_tdata[32*j +: 32]);
              miss++;
            end
          if (m_tuser !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, m_tuser);
            miss++;
          end
        end
      end
      errors <= errors + miss;
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_PER_PHASE = 192;
  localparam int STALL_LIMIT = 100000;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending;
  bit          gaps_on;
  int          idle_cycles;

  kpoint_mesh_zone_reduce DUT (.*);

  kmzr_checker u_checker (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic int gap_len();
    if (!gaps_on) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [39:0] point_beat(int na, int nb, int nc, int ia, int ib, int ic);
    logic [39:0] d;
    d = '0;
    d[6:0] = 7'(na); d[13:7] = 7'(nb); d[20:14] = 7'(nc);
    d[26:21] = 6'(ia); d[32:27] = 6'(ib); d[38:33] = 6'(ic);
    return d;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_point(logic [39:0] d);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_random_points(int count);
    int na, nb, nc;
    for (int k = 0; k < count; k++) begin
      // mostly valid points, a tenth of raw noise for the index check
      if ($urandom_range(0, 9) == 0) begin
        send_point({1'b0, 39'($urandom()) ^ {7'($urandom()), 32'd0}});
      end else begin
        na = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        nb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        nc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        send_point(point_beat(na, nb, nc, $urandom_range(0, na - 1),
                              $urandom_range(0, nb - 1), $urandom_range(0, nc - 1)));
      end
    end
  endtask

  task automatic load_metric(logic [31:0] aa, logic [31:0] bb, logic [31:0] cc,
                             logic [31:0] ab, logic [31:0] ac, logic [31:0] bc);
    reg_write(kmzr_pkg::REG_AA, aa); reg_write(kmzr_pkg::REG_BB, bb);
    reg_write(kmzr_pkg::REG_CC, cc); reg_write(kmzr_pkg::REG_AB, ab);
    reg_write(kmzr_pkg::REG_AC, ac); reg_write(kmzr_pkg::REG_BC, bc);
  endtask

  // Receiver: random holds, one long hold after a few results
  initial begin
    int beats;
    beats = 0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (beats == 8) begin
        m_tready <= 1'b0;
        repeat (30000) @(negedge clk);
        beats++;
      end else if (!gaps_on || $urandom_range(0, 9) < 7) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 400) : $urandom_range(0, 4))
          @(negedge clk);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) beats++;
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gaps_on = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: range ends, index faults, a beat with only the fill bit set
    send_point(point_beat(1, 1, 1, 0, 0, 0));
    send_point(point_beat(64, 64, 64, 0, 0, 0));
    send_point(point_beat(64, 64, 64, 63, 63, 63));
    send_point(point_beat(2, 3, 4, 1, 2, 3));
    send_point(point_beat(64, 1, 33, 32, 0, 16));
    send_point(point_beat(7, 8, 9, 3, 4, 4));
    send_point(point_beat(5, 5, 5, 5, 0, 0));
    send_point(point_beat(0, 4, 4, 0, 0, 0));
    send_point(point_beat(65, 4, 4, 0, 0, 0));
    send_point(point_beat(127, 127, 127, 63, 63, 63));
    send_point(point_beat(4, 4, 4, 0, 0, 4));
    send_point(point_beat(64, 64, 1, 63, 0, 1));
    send_point({1'b1, 39'd0});
    send_random_points(RANDOM_PER_PHASE - 13);
    drain();

    // Hexagonal-like metric, no gaps
    gaps_on = 1'b0;
    load_metric(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0080_0000, 32'h0, 32'h0);
    send_random_points(RANDOM_PER_PHASE);
    drain();

    // Skewed metric
    gaps_on = 1'b1;
    load_metric(32'h0040_0000, 32'h0200_0000, 32'h00C0_0000,
                32'hFFE0_0000, 32'h0010_0000, 32'hFFD0_0000);
    send_random_points(RANDOM_PER_PHASE);
    drain();

    // Register extremes
    load_metric(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_random_points(RANDOM_PER_PHASE);
    drain();

    // Tiny norms with large cross terms: clamped multiples and saturation
    load_metric(32'h1, 32'h1, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_random_points(RANDOM_PER_PHASE);
    drain();

    // Degenerate metric: negative and zero norms
    load_metric(32'h8000_0000, 32'h0, 32'hFF00_0000, 32'h0, 32'h0, 32'h0);
    send_random_points(RANDOM_PER_PHASE);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/kmzr_pkg.sv
rtl/core/kmzr_mul.sv
rtl/core/kmzr_div.sv
rtl/core/kpoint_mesh_zone_reduce.sv
test/kmzr_checker.sv
test/tb_top.sv
